FILE: rtl/core/evr_pkg.sv
// Shared types, constants and tables for the Euler vertex rotator.
package evr_pkg;

  localparam int PHASE_BITS      = 24;
  localparam int TRIG_BITS       = 16;
  localparam int CORDIC_ITERS    = 24;
  localparam int CORDIC_ITER_W   = $clog2(CORDIC_ITERS);
  localparam int CORDIC_GAIN_Q30 = 652032874;
  localparam int CORDIC_W        = 33;

  localparam int STEP_W   = 24;
  localparam int CENTER_W = 16;
  localparam int SWING_W  = 16;
  localparam int VERT_W   = 16;
  localparam int SCREEN_W = 18;
  localparam int DEPTH_W  = 16;
  localparam int OFF_W    = 18;
  localparam int OPA_W    = 20;
  localparam int RES_W    = 21;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W    = 24;

  localparam logic [STEP_W-1:0]          RST_STEP_X   = 24'd8011;
  localparam logic [STEP_W-1:0]          RST_STEP_Y   = 24'd13351;
  localparam logic [STEP_W-1:0]          RST_STEP_Z   = 24'd5340;
  localparam logic [CENTER_W-1:0]        RST_CENTER_X = 16'd32768;
  localparam logic [CENTER_W-1:0]        RST_CENTER_Y = 16'd8192;
  localparam logic signed [SWING_W-1:0]  RST_SWING_X  = 16'sd21709;
  localparam logic signed [SWING_W-1:0]  RST_SWING_Y  = -16'sd2867;
  localparam logic signed [OFF_W-1:0]    RST_OFF_X    = 18'sd54477;
  localparam logic signed [OFF_W-1:0]    RST_OFF_Y    = 18'sd8192;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_X   = 3'd0,
    REG_STEP_Y   = 3'd1,
    REG_STEP_Z   = 3'd2,
    REG_CENTER_X = 3'd3,
    REG_CENTER_Y = 3'd4,
    REG_SWING_X  = 3'd5,
    REG_SWING_Y  = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    OPA_X, OPA_Y, OPA_Z, OPA_T1, OPA_T2, OPA_U, OPA_SWX, OPA_SWY
  } opa_t;

  typedef enum logic [2:0] {
    OPB_CX = 3'd0, OPB_SX = 3'd1, OPB_CY = 3'd2,
    OPB_SY = 3'd3, OPB_CZ = 3'd4, OPB_SZ = 3'd5
  } opb_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_T1, DST_T2, DST_T3, DST_U, DST_RX, DST_RY, DST_RZ, DST_OFFX, DST_OFFY
  } dst_t;

  typedef struct packed {
    opa_t opa;
    opb_t opb;
    logic clear;
    logic sub;
    dst_t dst;
    logic last;
  } uop_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic sub;
  } mul_ctrl_t;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_ROTATE  = 4'd0;
  localparam logic [PC_W-1:0] PC_ADVANCE = 4'd12;

  // product sequence: rotation first, offset update after the CORDIC passes
  function automatic uop_t uop(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '{OPA_X, OPB_CX, 1'b1, 1'b0, DST_NONE, 1'b1};
    unique case (pc)
      4'd0:  u = '{OPA_Y,   OPB_CX, 1'b1, 1'b0, DST_NONE, 1'b0};
      4'd1:  u = '{OPA_Z,   OPB_SX, 1'b0, 1'b1, DST_T1,   1'b0};
      4'd2:  u = '{OPA_Y,   OPB_SX, 1'b1, 1'b0, DST_NONE, 1'b0};
      4'd3:  u = '{OPA_Z,   OPB_CX, 1'b0, 1'b0, DST_T2,   1'b0};
      4'd4:  u = '{OPA_X,   OPB_CY, 1'b1, 1'b0, DST_T3,   1'b0};
      4'd5:  u = '{OPA_T2,  OPB_SY, 1'b1, 1'b0, DST_U,    1'b0};
      4'd6:  u = '{OPA_U,   OPB_CZ, 1'b1, 1'b0, DST_NONE, 1'b0};
      4'd7:  u = '{OPA_T1,  OPB_SZ, 1'b0, 1'b1, DST_RX,   1'b0};
      4'd8:  u = '{OPA_U,   OPB_SZ, 1'b1, 1'b0, DST_NONE, 1'b0};
      4'd9:  u = '{OPA_T1,  OPB_CZ, 1'b0, 1'b0, DST_RY,   1'b0};
      4'd10: u = '{OPA_T2,  OPB_CY, 1'b1, 1'b0, DST_NONE, 1'b0};
      4'd11: u = '{OPA_X,   OPB_SY, 1'b0, 1'b1, DST_RZ,   1'b1};
      4'd12: u = '{OPA_SWX, OPB_CX, 1'b1, 1'b0, DST_OFFX, 1'b0};
      4'd13: u = '{OPA_SWY, OPB_SY, 1'b1, 1'b0, DST_OFFY, 1'b1};
      default: u = '{OPA_X, OPB_CX, 1'b1, 1'b0, DST_NONE, 1'b1};
    endcase
    return u;
  endfunction

  // arctan(2^-i) in turns * 2^32
  function automatic logic [31:0] atan_turns(input logic [CORDIC_ITER_W-1:0] i);
    logic [31:0] a;
    a = 32'h0;
    unique case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051D;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2E;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517C;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A2F;
      5'd19: a = 32'h00000517;
      5'd20: a = 32'h0000028B;
      5'd21: a = 32'h00000145;
      5'd22: a = 32'h000000A2;
      5'd23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/core/evr_smul.sv
// Bit-serial signed multiply-accumulate with half-up rounding of the sum.
module evr_smul #(
  parameter int TRIG_BITS = evr_pkg::TRIG_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  evr_pkg::mul_ctrl_t                  ctrl,
  input  logic signed [evr_pkg::OPA_W-1:0]    a,
  input  logic signed [TRIG_BITS-1:0]         b,
  output logic                                done,
  output logic signed [evr_pkg::RES_W-1:0]    rnd
);

  localparam int ACC_W = evr_pkg::OPA_W + TRIG_BITS + 2;
  localparam int CNT_W = $clog2(TRIG_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TRIG_BITS - 1);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (TRIG_BITS - 2);

  logic signed [ACC_W-1:0] acc, a_sh, term, acc_next, biased, shifted;
  logic [TRIG_BITS-1:0] b_sh;
  logic [CNT_W-1:0] cnt;
  logic busy, sub, neg;

  always_comb begin
    neg      = sub ^ (cnt == CNT_LAST);
    term     = b_sh[0] ? a_sh : '0;
    acc_next = neg ? acc - term : acc + term;
    biased   = acc + HALF;
    shifted  = biased >>> (TRIG_BITS - 1);
    rnd      = shifted[evr_pkg::RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      a_sh <= ACC_W'(a);
      b_sh <= b;
      sub  <= ctrl.sub;
      if (ctrl.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      acc  <= acc_next;
      a_sh <= a_sh <<< 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

FILE: rtl/core/evr_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of one phase angle.
module evr_cordic #(
  parameter int PHASE_BITS = evr_pkg::PHASE_BITS,
  parameter int TRIG_BITS  = evr_pkg::TRIG_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [PHASE_BITS-1:0]       phase,
  output logic                        done,
  output logic signed [TRIG_BITS-1:0] cos_val,
  output logic signed [TRIG_BITS-1:0] sin_val
);

  localparam int W   = evr_pkg::CORDIC_W;
  localparam int IW  = evr_pkg::CORDIC_ITER_W;
  localparam int ZSH = 32 - PHASE_BITS;
  localparam logic [IW-1:0] ITER_LAST = IW'(evr_pkg::CORDIC_ITERS - 1);
  localparam logic signed [W-1:0] GAIN = W'(evr_pkg::CORDIC_GAIN_Q30);
  localparam logic signed [W-1:0] HALF = W'(1) <<< (30 - TRIG_BITS);
  localparam logic signed [W-1:0] LIM  = W'((1 <<< (TRIG_BITS - 1)) - 1);

  logic signed [W-1:0] x, y, z, dx, dy, xb, yb, xs, ys, xc, yc;
  logic signed [TRIG_BITS-1:0] cc, ss;
  logic [IW-1:0] iter;
  logic [1:0] quad;
  logic busy, fin;

  always_comb begin
    dx = y >>> iter;
    dy = x >>> iter;
    xb = x + HALF;
    yb = y + HALF;
    xs = xb >>> (31 - TRIG_BITS);
    ys = yb >>> (31 - TRIG_BITS);
    xc = (xs > LIM) ? LIM : ((xs < -LIM) ? -LIM : xs);
    yc = (ys > LIM) ? LIM : ((ys < -LIM) ? -LIM : ys);
    cc = xc[TRIG_BITS-1:0];
    ss = yc[TRIG_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + IW'(1);
        if (iter == ITER_LAST) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= GAIN;
      y    <= '0;
      z    <= W'({{(W - PHASE_BITS + 2){1'b0}}, phase[PHASE_BITS-3:0]}) << ZSH;
      quad <= phase[PHASE_BITS-1:PHASE_BITS-2];
    end else if (busy) begin
      if (!z[W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - W'(evr_pkg::atan_turns(iter));
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + W'(evr_pkg::atan_turns(iter));
      end
    end
    if (fin) begin
      unique case (quad)
        2'd0: begin cos_val <= cc;  sin_val <= ss;  end
        2'd1: begin cos_val <= -ss; sin_val <= cc;  end
        2'd2: begin cos_val <= -cc; sin_val <= -ss; end
        2'd3: begin cos_val <= ss;  sin_val <= -cc; end
        default: begin cos_val <= cc; sin_val <= ss; end
      endcase
    end
  end

endmodule

FILE: rtl/core/euler_vertex_rotator.sv
// Euler vertex rotator top level: sequencer, state and output register.
// Rotate beat: 12 serial products in turn on the one bit-serial multiplier.
// Advance beat: three CORDIC passes plus two products.
// One beat at a time; the next is taken once the last one is done, a rotate beat's result in the output register.
// Reset: registers to defaults, angles zero, cosines full scale, sines zero.
module euler_vertex_rotator #(
  parameter int PHASE_BITS = evr_pkg::PHASE_BITS,
  parameter int TRIG_BITS  = evr_pkg::TRIG_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [evr_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [evr_pkg::CFG_W-1:0]              cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   func,
  input  logic signed [evr_pkg::VERT_W-1:0]      vert_x,
  input  logic signed [evr_pkg::VERT_W-1:0]      vert_y,
  input  logic signed [evr_pkg::VERT_W-1:0]      vert_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [evr_pkg::SCREEN_W-1:0]    screen_x,
  output logic signed [evr_pkg::SCREEN_W-1:0]    screen_y,
  output logic signed [evr_pkg::DEPTH_W-1:0]     depth_z
);

  localparam int OPA_W = evr_pkg::OPA_W;
  localparam int RES_W = evr_pkg::RES_W;
  localparam int OFF_W = evr_pkg::OFF_W;
  localparam int SUM_W = (PHASE_BITS > evr_pkg::STEP_W) ? PHASE_BITS : evr_pkg::STEP_W;
  localparam int SAT_W = RES_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ISSUE  = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_CSTART = 3'd3;
  localparam logic [2:0] S_CWAIT  = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  localparam logic signed [TRIG_BITS-1:0] TRIG_ONE = TRIG_BITS'((1 <<< (TRIG_BITS - 1)) - 1);
  localparam logic signed [SAT_W-1:0] SCR_MAX = SAT_W'((1 <<< (evr_pkg::SCREEN_W - 1)) - 1);
  localparam logic signed [SAT_W-1:0] SCR_MIN = -SCR_MAX - SAT_W'(1);
  localparam logic signed [RES_W-1:0] DEP_MAX = RES_W'((1 <<< (evr_pkg::DEPTH_W - 1)) - 1);
  localparam logic signed [RES_W-1:0] DEP_MIN = -DEP_MAX - RES_W'(1);

  logic [2:0] state;
  logic [evr_pkg::PC_W-1:0] pc;
  logic [1:0] axis;

  logic [evr_pkg::STEP_W-1:0] step_x, step_y, step_z;
  logic [evr_pkg::CENTER_W-1:0] center_x, center_y;
  logic signed [evr_pkg::SWING_W-1:0] swing_x, swing_y;
  logic [PHASE_BITS-1:0] phase [3];
  logic signed [TRIG_BITS-1:0] trig [6];
  logic signed [OFF_W-1:0] off_x, off_y;

  logic signed [evr_pkg::VERT_W-1:0] vx, vy, vz;
  logic signed [OPA_W-1:0] t1, t2, u;
  logic signed [RES_W-1:0] rx, ry, rz;

  evr_pkg::uop_t op;
  evr_pkg::mul_ctrl_t mul_ctrl;
  logic signed [OPA_W-1:0] opa;
  logic signed [TRIG_BITS-1:0] opb;
  logic mul_done, cor_done, cor_start;
  logic signed [RES_W-1:0] mul_rnd;
  logic signed [TRIG_BITS-1:0] cor_cos, cor_sin;
  logic signed [SAT_W-1:0] sum_x, sum_y;
  logic signed [evr_pkg::SCREEN_W-1:0] sat_x, sat_y;
  logic signed [evr_pkg::DEPTH_W-1:0] sat_z;
  logic in_acc;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    op = evr_pkg::uop(pc);
    unique case (op.opa)
      evr_pkg::OPA_X:   opa = OPA_W'(vx);
      evr_pkg::OPA_Y:   opa = OPA_W'(vy);
      evr_pkg::OPA_Z:   opa = OPA_W'(vz);
      evr_pkg::OPA_T1:  opa = t1;
      evr_pkg::OPA_T2:  opa = t2;
      evr_pkg::OPA_U:   opa = u;
      evr_pkg::OPA_SWX: opa = OPA_W'(swing_x);
      evr_pkg::OPA_SWY: opa = OPA_W'(swing_y);
      default:          opa = OPA_W'(vx);
    endcase
    unique case (op.opb)
      evr_pkg::OPB_CX: opb = trig[0];
      evr_pkg::OPB_SX: opb = trig[1];
      evr_pkg::OPB_CY: opb = trig[2];
      evr_pkg::OPB_SY: opb = trig[3];
      evr_pkg::OPB_CZ: opb = trig[4];
      evr_pkg::OPB_SZ: opb = trig[5];
      default:         opb = trig[0];
    endcase
    mul_ctrl.start = (state == S_ISSUE);
    mul_ctrl.clear = op.clear;
    mul_ctrl.sub   = op.sub;
    cor_start      = (state == S_CSTART);

    sum_x = SAT_W'(rx) + SAT_W'(off_x);
    sum_y = SAT_W'(ry) + SAT_W'(off_y);
    sat_x = (sum_x > SCR_MAX) ? SCR_MAX[evr_pkg::SCREEN_W-1:0] :
            (sum_x < SCR_MIN) ? SCR_MIN[evr_pkg::SCREEN_W-1:0] :
            sum_x[evr_pkg::SCREEN_W-1:0];
    sat_y = (sum_y > SCR_MAX) ? SCR_MAX[evr_pkg::SCREEN_W-1:0] :
            (sum_y < SCR_MIN) ? SCR_MIN[evr_pkg::SCREEN_W-1:0] :
            sum_y[evr_pkg::SCREEN_W-1:0];
    sat_z = (rz > DEP_MAX) ? DEP_MAX[evr_pkg::DEPTH_W-1:0] :
            (rz < DEP_MIN) ? DEP_MIN[evr_pkg::DEPTH_W-1:0] :
            rz[evr_pkg::DEPTH_W-1:0];
  end

  evr_smul #(
    .TRIG_BITS(TRIG_BITS)
  ) u_smul (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mul_ctrl),
    .a    (opa),
    .b    (opb),
    .done (mul_done),
    .rnd  (mul_rnd)
  );

  evr_cordic #(
    .PHASE_BITS(PHASE_BITS),
    .TRIG_BITS (TRIG_BITS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .phase   (phase[axis]),
    .done    (cor_done),
    .cos_val (cor_cos),
    .sin_val (cor_sin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= evr_pkg::PC_ROTATE;
      axis      <= 2'd0;
      out_valid <= 1'b0;
      step_x    <= evr_pkg::RST_STEP_X;
      step_y    <= evr_pkg::RST_STEP_Y;
      step_z    <= evr_pkg::RST_STEP_Z;
      center_x  <= evr_pkg::RST_CENTER_X;
      center_y  <= evr_pkg::RST_CENTER_Y;
      swing_x   <= evr_pkg::RST_SWING_X;
      swing_y   <= evr_pkg::RST_SWING_Y;
      off_x     <= evr_pkg::RST_OFF_X;
      off_y     <= evr_pkg::RST_OFF_Y;
      for (int i = 0; i < 3; i++) begin
        phase[i]       <= '0;
        trig[2 * i]     <= TRIG_ONE;
        trig[2 * i + 1] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          evr_pkg::REG_STEP_X:   step_x   <= cfg_data[evr_pkg::STEP_W-1:0];
          evr_pkg::REG_STEP_Y:   step_y   <= cfg_data[evr_pkg::STEP_W-1:0];
          evr_pkg::REG_STEP_Z:   step_z   <= cfg_data[evr_pkg::STEP_W-1:0];
          evr_pkg::REG_CENTER_X: center_x <= cfg_data[evr_pkg::CENTER_W-1:0];
          evr_pkg::REG_CENTER_Y: center_y <= cfg_data[evr_pkg::CENTER_W-1:0];
          evr_pkg::REG_SWING_X:  swing_x  <= cfg_data[evr_pkg::SWING_W-1:0];
          evr_pkg::REG_SWING_Y:  swing_y  <= cfg_data[evr_pkg::SWING_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (func) begin
              phase[0] <= PHASE_BITS'(SUM_W'(phase[0]) + SUM_W'(step_x));
              phase[1] <= PHASE_BITS'(SUM_W'(phase[1]) + SUM_W'(step_y));
              phase[2] <= PHASE_BITS'(SUM_W'(phase[2]) + SUM_W'(step_z));
              axis     <= 2'd0;
              state    <= S_CSTART;
            end else begin
              pc    <= evr_pkg::PC_ROTATE;
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: state <= S_MUL;
        S_MUL: begin
          if (mul_done) begin
            unique case (op.dst)
              evr_pkg::DST_T1:   t1    <= OPA_W'(mul_rnd);
              evr_pkg::DST_T2:   t2    <= OPA_W'(mul_rnd);
              evr_pkg::DST_T3:   u     <= OPA_W'(mul_rnd);
              evr_pkg::DST_U:    u     <= u + OPA_W'(mul_rnd);
              evr_pkg::DST_RX:   rx    <= mul_rnd;
              evr_pkg::DST_RY:   ry    <= mul_rnd;
              evr_pkg::DST_RZ:   rz    <= mul_rnd;
              evr_pkg::DST_OFFX: off_x <= OFF_W'(center_x) + OFF_W'(mul_rnd);
              evr_pkg::DST_OFFY: off_y <= OFF_W'(center_y) + OFF_W'(mul_rnd);
              default: ;
            endcase
            if (op.last) begin
              state <= (pc == evr_pkg::PC_ADVANCE + evr_pkg::PC_W'(1)) ? S_IDLE : S_OUT;
            end else begin
              pc    <= pc + evr_pkg::PC_W'(1);
              state <= S_ISSUE;
            end
          end
        end
        S_CSTART: state <= S_CWAIT;
        S_CWAIT: begin
          if (cor_done) begin
            trig[{axis, 1'b0}] <= cor_cos;
            trig[{axis, 1'b1}] <= cor_sin;
            if (axis == 2'd2) begin
              pc    <= evr_pkg::PC_ADVANCE;
              state <= S_ISSUE;
            end else begin
              axis  <= axis + 2'd1;
              state <= S_CSTART;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      vx <= vert_x;
      vy <= vert_y;
      vz <= vert_z;
    end
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      screen_x <= sat_x;
      screen_y <= sat_y;
      depth_z  <= sat_z;
    end
  end

endmodule
